// ----- hw/rtl/rlm_pkg.sv -----
// ----------------------------------------------------------------------------
// rlm_pkg: shared types and constants of the RMS level meter
// Field widths, fixed-point limits, decay constants and the item
// structs used by the top level and the RMS unit.
// ----------------------------------------------------------------------------
package rlm_pkg;

    // field widths
    localparam int CH_FIELD_W = 4;
    localparam int SAMPLE_W   = 24;
    localparam int LEVEL_W    = 24;
    localparam int BLEN_W     = 13;
    localparam int SQ_W       = 2 * SAMPLE_W;
    localparam int SUM_W      = 60;
    localparam int ROOT_W     = SUM_W / 2;

    // defaults
    localparam int CHANNELS_DEF = 16;
    localparam int MAX_BLOCK    = 4096;

    localparam logic [BLEN_W-1:0]  BLOCK_LEN_RESET = BLEN_W'(512);
    localparam logic [LEVEL_W-1:0] LEVEL_MAX       = LEVEL_W'(8388608);

    // decay by 19/20: x*19, then floor(x/4) times ceil(2^34/5), shift by 34
    localparam int                 DECAY_NUM_W = 5;
    localparam logic [DECAY_NUM_W-1:0] DECAY_NUM = DECAY_NUM_W'(19);
    localparam int                 DECAY_X_W   = LEVEL_W + DECAY_NUM_W;
    localparam int                 RECIP_W     = 32;
    localparam logic [RECIP_W-1:0] RECIP5      = 32'hCCCC_CCCD;
    localparam int                 RECIP_SHIFT = 34;
    localparam int                 DECAY_P_W   = DECAY_X_W - 2 + RECIP_W;

    // input item
    typedef struct packed {
        logic [CH_FIELD_W-1:0]      channel;
        logic signed [SAMPLE_W-1:0] pre_sample;
        logic signed [SAMPLE_W-1:0] post_sample;
        logic                       present;
        logic                       last_in_block;
    } t_in_item;

    // result item
    typedef struct packed {
        logic [CH_FIELD_W-1:0] out_channel;
        logic [LEVEL_W-1:0]    input_level;
        logic [LEVEL_W-1:0]    output_level;
    } t_out_item;

    // one channel's state entry
    typedef struct packed {
        logic [SUM_W-1:0]   pre_sum;
        logic [SUM_W-1:0]   post_sum;
        logic [LEVEL_W-1:0] held_in;
        logic [LEVEL_W-1:0] held_out;
    } t_entry;

    // request and response of the RMS unit
    typedef struct packed {
        logic              start;
        logic [SUM_W-1:0]  sum;
        logic [BLEN_W-1:0] divisor;
    } t_rms_req;

    typedef struct packed {
        logic               done;
        logic [LEVEL_W-1:0] level;
    } t_rms_rsp;

endpackage

// ----- hw/rtl/rlm_stream_if.sv -----
// ----------------------------------------------------------------------------
// rlm_stream_if: valid/ready item channel
// Carries one payload item per handshake; the payload type is a parameter.
// ----------------------------------------------------------------------------
interface rlm_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/rlm_rms_unit.sv -----
// ----------------------------------------------------------------------------
// rlm_rms_unit: iterative mean and square root
// Computes min(floor(sqrt(floor(sum / n))), 1.0) with a one-bit-per-cycle
// restoring divider followed by a one-digit-per-cycle square root.
// ----------------------------------------------------------------------------
module rlm_rms_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rlm_pkg::t_rms_req i_req,
    output rlm_pkg::t_rms_rsp o_rsp
);
    import rlm_pkg::*;

    localparam int DIV_STEPS  = SUM_W;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int CNT_W      = $clog2(DIV_STEPS);
    localparam int SREM_W     = ROOT_W + 2;

    localparam logic [1:0] U_IDLE = 2'd0;
    localparam logic [1:0] U_DIV  = 2'd1;
    localparam logic [1:0] U_SQRT = 2'd2;
    localparam logic [1:0] U_DONE = 2'd3;

    logic [1:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_cnt;
    logic [SUM_W-1:0]  r_quo;      // dividend shifts out, quotient shifts in
    logic [BLEN_W-1:0] r_rem;
    logic [BLEN_W-1:0] r_div;
    logic [SUM_W-1:0]  r_rad;      // radicand, two bits consumed per step
    logic [ROOT_W-1:0] r_root;
    logic [SREM_W-1:0] r_srem;

    // divider step
    logic [BLEN_W:0]   div_tmp;
    logic              div_ge;
    logic [SUM_W-1:0]  quo_next;
    assign div_tmp  = {r_rem, r_quo[SUM_W-1]};
    assign div_ge   = div_tmp >= {1'b0, r_div};
    assign quo_next = {r_quo[SUM_W-2:0], div_ge};

    // square root step
    logic [SREM_W+1:0] sq_tmp;
    logic [SREM_W+1:0] sq_trial;
    logic              sq_ge;
    assign sq_tmp   = {r_srem, r_rad[SUM_W-1 -: 2]};
    assign sq_trial = {2'b00, r_root, 2'b01};
    assign sq_ge    = sq_tmp >= sq_trial;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            U_IDLE: if (i_req.start) n_state = U_DIV;
            U_DIV:  if (r_cnt == CNT_W'(DIV_STEPS - 1)) n_state = U_SQRT;
            U_SQRT: if (r_cnt == CNT_W'(SQRT_STEPS - 1)) n_state = U_DONE;
            U_DONE: n_state = U_IDLE;
            default: n_state = U_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= U_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            U_IDLE: begin
                r_quo <= i_req.sum;
                r_div <= i_req.divisor;
                r_rem <= '0;
                r_cnt <= '0;
            end
            U_DIV: begin
                r_rem <= div_ge ? BLEN_W'(div_tmp - {1'b0, r_div}) : div_tmp[BLEN_W-1:0];
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    r_rad  <= quo_next;
                    r_root <= '0;
                    r_srem <= '0;
                    r_cnt  <= '0;
                end else begin
                    r_quo <= quo_next;
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            U_SQRT: begin
                r_srem <= sq_ge ? SREM_W'(sq_tmp - sq_trial) : SREM_W'(sq_tmp);
                r_root <= {r_root[ROOT_W-2:0], sq_ge};
                r_rad  <= {r_rad[SUM_W-3:0], 2'b00};
                r_cnt  <= r_cnt + 1'b1;
            end
            default: begin
            end
        endcase
    end

    // result, saturated to 1.0
    assign o_rsp.done  = (r_state == U_DONE);
    assign o_rsp.level = (r_root > ROOT_W'(LEVEL_MAX)) ? LEVEL_MAX : r_root[LEVEL_W-1:0];

endmodule

// ----- hw/rtl/rms_level_meter_with_decay.sv -----
// ----------------------------------------------------------------------------
// rms_level_meter_with_decay: per-channel RMS meter with peak hold and decay
// Accumulates squares per channel in a state memory and reports held levels
// at the end of each channel's block.
// ----------------------------------------------------------------------------
// Usage:
//   i_in takes one sample pair per item (channel, pre/post sample, present,
//   last_in_block). o_out gives one item (channel, input and output level)
//   for every in-range item that has last_in_block set; other items give none.
//   i_cfg_we/i_cfg_wdata write block_length; the user must write only while the block is idle (unchecked).
// Timing:
//   One item at a time; the state entry is read, updated and written back.
//   A sample that does not close a block passes the square and accumulate
//   states. A closing item with present set runs the shared divide/square-root
//   unit twice (start, 60 divider steps, 30 root steps and the done cycle
//   each), then the decay states DEC1 and DEC2; an absent closing item skips the unit.
//   The result enters the output register at the write-back edge.
// Reset:
//   Synchronous, active low. All channel entries read as zero afterward
//   (a valid flag per entry), block_length returns to 512.
// Stall:
//   A waiting result does not block further items; a second result waits at
//   its write-back until the output register is taken.
// ----------------------------------------------------------------------------
module rms_level_meter_with_decay #(
    parameter int CHANNELS = rlm_pkg::CHANNELS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [rlm_pkg::BLEN_W-1:0] i_cfg_wdata,
    rlm_stream_if.sink                i_in,
    rlm_stream_if.source              o_out
);
    import rlm_pkg::*;

    localparam int CH_AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_SQ        = 4'd1;
    localparam logic [3:0] S_ACC       = 4'd2;
    localparam logic [3:0] S_PRE_GO    = 4'd3;
    localparam logic [3:0] S_PRE_WAIT  = 4'd4;
    localparam logic [3:0] S_POST_GO   = 4'd5;
    localparam logic [3:0] S_POST_WAIT = 4'd6;
    localparam logic [3:0] S_DEC1      = 4'd7;
    localparam logic [3:0] S_DEC2      = 4'd8;
    localparam logic [3:0] S_WB        = 4'd9;

    // magnitude of a signed Q1.23 sample; the most negative value maps to 1.0
    function automatic logic [SAMPLE_W-1:0] mag_of(input logic [SAMPLE_W-1:0] s);
        return s[SAMPLE_W-1] ? (~s + 1'b1) : s;
    endfunction

    logic [3:0]          r_state, n_state;
    logic [BLEN_W-1:0]   r_block_length;
    t_in_item            r_item;
    logic [CH_AW-1:0]    r_addr;

    // state memory and per-entry valid flags
    t_entry              mem [CHANNELS];
    logic [CHANNELS-1:0] r_valid;
    t_entry              r_rd_data;
    logic                r_rd_valid;
    t_entry              ent;
    logic                mem_we;
    t_entry              mem_wdata;

    logic [SQ_W-1:0]     r_sq_pre, r_sq_post;
    logic [SUM_W-1:0]    r_pre_sum, r_post_sum;
    logic [SUM_W:0]      add_pre, add_post;
    logic [SUM_W-1:0]    sum_pre, sum_post;
    logic [LEVEL_W-1:0]  r_rms_in, r_rms_out;
    logic [DECAY_X_W-1:0] r_dx_in, r_dx_out;
    logic [DECAY_P_W-1:0] r_dp_in, r_dp_out;
    logic [LEVEL_W-1:0]  dec_in, dec_out, new_in, new_out;

    logic                r_out_valid;
    t_out_item           r_out_data;
    logic                out_free;

    logic                in_acc;
    logic                in_range;
    logic [CH_AW-1:0]    in_addr;
    logic [BLEN_W-1:0]   divisor;
    t_rms_req            rms_req;
    t_rms_rsp            rms_rsp;

    assign in_acc   = i_in.valid && i_in.ready;
    assign in_range = 32'(i_in.data.channel) < CHANNELS;
    assign in_addr  = CH_AW'(i_in.data.channel);
    assign out_free = !r_out_valid || o_out.ready;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_length <= BLOCK_LEN_RESET;
        end else if (i_cfg_we) begin
            r_block_length <= i_cfg_wdata;
        end
    end

    // divisor clamped to [1, MAX_BLOCK]
    always_comb begin
        if (r_block_length == '0) begin
            divisor = BLEN_W'(1);
        end else if (32'(r_block_length) > MAX_BLOCK) begin
            divisor = BLEN_W'(MAX_BLOCK);
        end else begin
            divisor = r_block_length;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:      if (in_acc && in_range) n_state = S_SQ;
            S_SQ:        n_state = S_ACC;
            S_ACC: begin
                if (!r_item.last_in_block) begin
                    n_state = S_IDLE;
                end else if (r_item.present) begin
                    n_state = S_PRE_GO;
                end else begin
                    n_state = S_DEC1;
                end
            end
            S_PRE_GO:    n_state = S_PRE_WAIT;
            S_PRE_WAIT:  if (rms_rsp.done) n_state = S_POST_GO;
            S_POST_GO:   n_state = S_POST_WAIT;
            S_POST_WAIT: if (rms_rsp.done) n_state = S_DEC1;
            S_DEC1:      n_state = S_DEC2;
            S_DEC2:      n_state = S_WB;
            S_WB:        if (out_free) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign i_in.ready = (r_state == S_IDLE);

    // entry as read, zero until first written
    assign ent = r_rd_valid ? r_rd_data : '0;

    // saturating accumulation
    assign add_pre  = {1'b0, ent.pre_sum}  + (SUM_W + 1)'(r_sq_pre);
    assign add_post = {1'b0, ent.post_sum} + (SUM_W + 1)'(r_sq_post);
    assign sum_pre  = add_pre[SUM_W]  ? '1 : add_pre[SUM_W-1:0];
    assign sum_post = add_post[SUM_W] ? '1 : add_post[SUM_W-1:0];

    // decay: floor(old * 19 / 20), then peak hold
    assign dec_in  = r_dp_in[RECIP_SHIFT +: LEVEL_W];
    assign dec_out = r_dp_out[RECIP_SHIFT +: LEVEL_W];
    assign new_in  = (r_rms_in > dec_in) ? r_rms_in : dec_in;
    assign new_out = (r_rms_out > dec_out) ? r_rms_out : dec_out;

    // write-back
    always_comb begin
        mem_we    = 1'b0;
        mem_wdata = ent;
        if (r_state == S_ACC && !r_item.last_in_block) begin
            mem_we             = 1'b1;
            mem_wdata.pre_sum  = sum_pre;
            mem_wdata.post_sum = sum_post;
        end else if (r_state == S_WB && out_free) begin
            mem_we             = 1'b1;
            mem_wdata.pre_sum  = '0;
            mem_wdata.post_sum = '0;
            mem_wdata.held_in  = new_in;
            mem_wdata.held_out = new_out;
        end
    end

    // memory: read at accept, write at the end of the item
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rd_data <= mem[in_addr];
        end
        if (mem_we) begin
            mem[r_addr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_rd_valid <= r_valid[in_addr];
            end
            if (mem_we) begin
                r_valid[r_addr] <= 1'b1;
            end
        end
    end

    // item datapath
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_item <= i_in.data;
            r_addr <= in_addr;
        end
        if (r_state == S_SQ) begin
            r_sq_pre  <= r_item.present ? SQ_W'(mag_of(r_item.pre_sample))
                                          * SQ_W'(mag_of(r_item.pre_sample))
                                        : '0;
            r_sq_post <= r_item.present ? SQ_W'(mag_of(r_item.post_sample))
                                          * SQ_W'(mag_of(r_item.post_sample))
                                        : '0;
        end
        if (r_state == S_ACC) begin
            r_pre_sum  <= sum_pre;
            r_post_sum <= sum_post;
            r_rms_in   <= '0;
            r_rms_out  <= '0;
        end
        if (r_state == S_PRE_WAIT && rms_rsp.done) begin
            r_rms_in <= rms_rsp.level;
        end
        if (r_state == S_POST_WAIT && rms_rsp.done) begin
            r_rms_out <= rms_rsp.level;
        end
        if (r_state == S_DEC1) begin
            r_dx_in  <= DECAY_X_W'(ent.held_in)  * DECAY_X_W'(DECAY_NUM);
            r_dx_out <= DECAY_X_W'(ent.held_out) * DECAY_X_W'(DECAY_NUM);
        end
        if (r_state == S_DEC2) begin
            r_dp_in  <= DECAY_P_W'(r_dx_in[DECAY_X_W-1:2])  * DECAY_P_W'(RECIP5);
            r_dp_out <= DECAY_P_W'(r_dx_out[DECAY_X_W-1:2]) * DECAY_P_W'(RECIP5);
        end
    end

    // shared mean and root unit
    always_comb begin
        rms_req.start   = (r_state == S_PRE_GO) || (r_state == S_POST_GO);
        rms_req.sum     = (r_state == S_POST_GO) ? r_post_sum : r_pre_sum;
        rms_req.divisor = divisor;
    end

    rlm_rms_unit u_rms (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (rms_req),
        .o_rsp   (rms_rsp)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_WB && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_WB && out_free) begin
            r_out_data.out_channel  <= r_item.channel;
            r_out_data.input_level  <= new_in;
            r_out_data.output_level <= new_out;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

endmodule
